/* rtl/core/scd_pkg.sv */
// shared types, constants and coefficient table for the sine/cosine degrees unit
// no dependencies; imported by every module of the block
package scd_pkg;

    typedef logic signed [63:0] word_t;

    // values carried alongside the series evaluation
    typedef struct packed {
        logic  command;
        word_t x_rad;
        word_t y_sq;
    } scd_carry_t;

    // command codes
    localparam logic CMD_SINE   = 1'b0;
    localparam logic CMD_COSINE = 1'b1;

    // fraction bits of the internal fixed point format
    localparam int FRAC = 56;
    // degrees Q16.16 times Q60 constant down to FRAC fraction bits
    localparam int RAD_SHIFT = 16 + 60 - FRAC;
    // Q2.30 output from FRAC fraction bits
    localparam int OUT_SHIFT = FRAC - 30;

    localparam logic [63:0] TWO_56 = 64'd1 << FRAC;
    localparam word_t ONE_Q56 = word_t'(TWO_56);
    localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
    localparam word_t RAD_PER_DEG = word_t'((PI_Q60 + 64'd90) / 64'd180);

    // angle reduction: 360 degrees in Q16.16 is 45 * 2^19
    localparam int LOW_BITS = 19;
    localparam logic [12:0] TURN_DIV = 13'd45;
    localparam logic [27:0] RECIP45 = 28'd23302;
    localparam logic signed [25:0] FULL_TURN = 26'sd23592960;
    localparam logic signed [25:0] HALF_TURN = 26'sd11796480;

    localparam logic [30:0] ONE_Q30 = 31'd1073741824;

    // round(2^56 / m!), zero once m! leaves 64 bits
    localparam word_t INV_FACT [32] = '{
        word_t'((TWO_56 + 64'd1 / 64'd2) / 64'd1),
        word_t'((TWO_56 + 64'd1 / 64'd2) / 64'd1),
        word_t'((TWO_56 + 64'd2 / 64'd2) / 64'd2),
        word_t'((TWO_56 + 64'd6 / 64'd2) / 64'd6),
        word_t'((TWO_56 + 64'd24 / 64'd2) / 64'd24),
        word_t'((TWO_56 + 64'd120 / 64'd2) / 64'd120),
        word_t'((TWO_56 + 64'd720 / 64'd2) / 64'd720),
        word_t'((TWO_56 + 64'd5040 / 64'd2) / 64'd5040),
        word_t'((TWO_56 + 64'd40320 / 64'd2) / 64'd40320),
        word_t'((TWO_56 + 64'd362880 / 64'd2) / 64'd362880),
        word_t'((TWO_56 + 64'd3628800 / 64'd2) / 64'd3628800),
        word_t'((TWO_56 + 64'd39916800 / 64'd2) / 64'd39916800),
        word_t'((TWO_56 + 64'd479001600 / 64'd2) / 64'd479001600),
        word_t'((TWO_56 + 64'd6227020800 / 64'd2) / 64'd6227020800),
        word_t'((TWO_56 + 64'd87178291200 / 64'd2) / 64'd87178291200),
        word_t'((TWO_56 + 64'd1307674368000 / 64'd2) / 64'd1307674368000),
        word_t'((TWO_56 + 64'd20922789888000 / 64'd2) / 64'd20922789888000),
        word_t'((TWO_56 + 64'd355687428096000 / 64'd2) / 64'd355687428096000),
        word_t'((TWO_56 + 64'd6402373705728000 / 64'd2) / 64'd6402373705728000),
        word_t'((TWO_56 + 64'd121645100408832000 / 64'd2) / 64'd121645100408832000),
        word_t'((TWO_56 + 64'd2432902008176640000 / 64'd2) / 64'd2432902008176640000),
        64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0,
        64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0
    };

    // alternating series coefficient of term k
    function automatic word_t coeff(input int unsigned k, input logic cosine);
        logic [4:0] m;
        word_t      c;
        m = (cosine == CMD_COSINE) ? 5'(2 * k) : 5'(2 * k + 1);
        c = INV_FACT[m];
        return k[0] ? -c : c;
    endfunction

endpackage

/* rtl/core/scd_mul.sv */
// signed 64x64 multiply, rounded half away from zero after a right shift, saturated
// four pipeline stages on 32x32 partial products; uses scd_pkg
module scd_mul #(
    parameter int SHIFT  = 56,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  scd_pkg::word_t    a,
    input  scd_pkg::word_t    b,
    input  logic [SIDE_W-1:0] side_in,
    output logic              out_valid,
    input  logic              out_ready,
    output scd_pkg::word_t    prod,
    output logic [SIDE_W-1:0] side_out
);
    import scd_pkg::*;

    localparam logic [127:0] RND = 128'd1 << (SHIFT - 1);
    localparam logic [63:0] MAG_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    logic [3:0] v_reg;
    logic [3:0] ld;

    logic [63:0]       ua_next, ub_next;
    logic [63:0]       ua_reg, ub_reg;
    logic              neg0_reg, neg1_reg, neg2_reg;
    logic [SIDE_W-1:0] side0_reg, side1_reg, side2_reg, side3_reg;
    logic [63:0]       p00_reg, p01_reg, p10_reg, p11_reg;
    logic [33:0]       mid_w;
    logic [63:0]       hi_w;
    logic [127:0]      sum_w, shifted_w;
    logic [63:0]       mag_next, mag_reg;
    word_t             prod_reg;

    // stall chain: a stage loads when empty or when its successor loads
    always_comb
    begin
        ld[3] = !v_reg[3] || out_ready;
        for (int j = 2; j >= 0; j--)
        begin
            ld[j] = !v_reg[j] || ld[j+1];
        end
    end

    assign in_ready = ld[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (ld[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int j = 1; j < 4; j++)
            begin
                if (ld[j])
                begin
                    v_reg[j] <= v_reg[j-1];
                end
            end
        end
    end

    // stage 0: magnitudes and result sign
    assign ua_next = a[63] ? (64'd0 - 64'(a)) : 64'(a);
    assign ub_next = b[63] ? (64'd0 - 64'(b)) : 64'(b);

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            ua_reg    <= ua_next;
            ub_reg    <= ub_next;
            neg0_reg  <= a[63] ^ b[63];
            side0_reg <= side_in;
        end
    end

    // stage 1: four 32x32 partial products
    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            p00_reg   <= 64'(ua_reg[31:0]) * 64'(ub_reg[31:0]);
            p01_reg   <= 64'(ua_reg[31:0]) * 64'(ub_reg[63:32]);
            p10_reg   <= 64'(ua_reg[63:32]) * 64'(ub_reg[31:0]);
            p11_reg   <= 64'(ua_reg[63:32]) * 64'(ub_reg[63:32]);
            neg1_reg  <= neg0_reg;
            side1_reg <= side0_reg;
        end
    end

    // stage 2: assemble, round, shift and saturate the magnitude
    always_comb
    begin
        mid_w = 34'(p00_reg[63:32]) + 34'(p01_reg[31:0]) + 34'(p10_reg[31:0]);
        hi_w  = p11_reg + 64'(p01_reg[63:32]) + 64'(p10_reg[63:32]) + 64'(mid_w[33:32]);
        sum_w = {hi_w, mid_w[31:0], p00_reg[31:0]} + RND;
        shifted_w = sum_w >> SHIFT;
        mag_next  = (|shifted_w[127:63]) ? MAG_MAX : shifted_w[63:0];
    end

    always_ff @(posedge clk)
    begin
        if (ld[2])
        begin
            mag_reg   <= mag_next;
            neg2_reg  <= neg1_reg;
            side2_reg <= side1_reg;
        end
    end

    // stage 3: apply the sign
    always_ff @(posedge clk)
    begin
        if (ld[3])
        begin
            prod_reg  <= neg2_reg ? -word_t'(mag_reg) : word_t'(mag_reg);
            side3_reg <= side2_reg;
        end
    end

    assign out_valid = v_reg[3];
    assign prod      = prod_reg;
    assign side_out  = side3_reg;

endmodule

/* rtl/core/scd_reduce.sv */
// reduces a Q16.16 degree angle modulo 360 into [-180, 180], three stages
// uses scd_pkg
module scd_reduce (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic signed [31:0]   angle_deg,
    input  logic                 command,
    output logic                 out_valid,
    input  logic                 out_ready,
    output scd_pkg::word_t       angle_red,
    output logic                 command_out
);
    import scd_pkg::*;

    logic [2:0] v_reg;
    logic [2:0] ld;
    logic       cmd0_reg, cmd1_reg, cmd2_reg;

    logic [31:0]        mag_w;
    logic [27:0]        qprod_w;
    logic               neg0_reg;
    logic [LOW_BITS-1:0] low0_reg;
    logic [12:0]        hi0_reg;
    logic [6:0]         q0_reg;

    logic [12:0]        rem_w;
    logic [24:0]        rmag_w;
    logic signed [25:0] r1_reg;
    logic signed [25:0] r2_next, r2_reg;

    always_comb
    begin
        ld[2] = !v_reg[2] || out_ready;
        ld[1] = !v_reg[1] || ld[2];
        ld[0] = !v_reg[0] || ld[1];
    end

    assign in_ready = ld[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (ld[0])
            begin
                v_reg[0] <= in_valid;
            end
            if (ld[1])
            begin
                v_reg[1] <= v_reg[0];
            end
            if (ld[2])
            begin
                v_reg[2] <= v_reg[1];
            end
        end
    end

    // stage 0: magnitude and quotient of the upper bits by 45 via reciprocal
    assign mag_w   = angle_deg[31] ? (32'd0 - 32'(angle_deg)) : 32'(angle_deg);
    assign qprod_w = 28'(mag_w[31:LOW_BITS]) * RECIP45;

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            neg0_reg <= angle_deg[31];
            low0_reg <= mag_w[LOW_BITS-1:0];
            hi0_reg  <= mag_w[31:LOW_BITS];
            q0_reg   <= qprod_w[26:20];
            cmd0_reg <= command;
        end
    end

    // stage 1: remainder, truncating toward zero like integer modulo
    assign rem_w  = hi0_reg - 13'(q0_reg) * TURN_DIV;
    assign rmag_w = {rem_w[5:0], low0_reg};

    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            r1_reg   <= neg0_reg ? -$signed(26'(rmag_w)) : $signed(26'(rmag_w));
            cmd1_reg <= cmd0_reg;
        end
    end

    // stage 2: fold into the half turn, exactly +-180 kept as is
    always_comb
    begin
        priority if (r1_reg > HALF_TURN)
        begin
            r2_next = r1_reg - FULL_TURN;
        end
        else if (r1_reg < -HALF_TURN)
        begin
            r2_next = r1_reg + FULL_TURN;
        end
        else
        begin
            r2_next = r1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[2])
        begin
            r2_reg   <= r2_next;
            cmd2_reg <= cmd1_reg;
        end
    end

    assign out_valid   = v_reg[2];
    assign angle_red   = word_t'(r2_reg);
    assign command_out = cmd2_reg;

endmodule

/* rtl/core/scd_cell.sv */
// one Horner cell: adds its series coefficient, then multiplies by the square
// the last cell multiplies by the angle for sine or by one for cosine; uses scd_pkg, scd_mul
module scd_cell #(
    parameter int   K_IDX = 0,
    parameter logic LAST  = 1'b0
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  scd_pkg::word_t      prod_in,
    input  scd_pkg::scd_carry_t carry_in,
    output logic                out_valid,
    input  logic                out_ready,
    output scd_pkg::word_t      prod_out,
    output scd_pkg::scd_carry_t carry_out
);
    import scd_pkg::*;

    localparam word_t C_SIN = coeff(K_IDX, CMD_SINE);
    localparam word_t C_COS = coeff(K_IDX, CMD_COSINE);
    localparam int CARRY_W = $bits(scd_carry_t);

    logic             v_reg;
    logic             ld;
    logic             mul_ready;
    word_t            p_next, b_next;
    word_t            p_reg, b_reg;
    scd_carry_t       carry_reg;
    logic [CARRY_W-1:0] side_w;

    assign ld       = !v_reg || mul_ready;
    assign in_ready = ld;

    // coefficient add and multiplier operand select
    always_comb
    begin
        p_next = ((carry_in.command == CMD_COSINE) ? C_COS : C_SIN) + prod_in;
        if (LAST)
        begin
            b_next = (carry_in.command == CMD_COSINE) ? ONE_Q56 : carry_in.x_rad;
        end
        else
        begin
            b_next = carry_in.y_sq;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (ld)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld)
        begin
            p_reg     <= p_next;
            b_reg     <= b_next;
            carry_reg <= carry_in;
        end
    end

    // rounded product hands on to the next cell
    scd_mul #(
        .SHIFT  (FRAC),
        .SIDE_W (CARRY_W)
    ) u_mul (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v_reg),
        .in_ready  (mul_ready),
        .a         (p_reg),
        .b         (b_reg),
        .side_in   (CARRY_W'(carry_reg)),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .prod      (prod_out),
        .side_out  (side_w)
    );

    assign carry_out = scd_carry_t'(side_w);

endmodule

/* rtl/core/sine_cosine_degrees_unit.sv */
// Sine or cosine of a Q16.16 degree angle as Q2.30, one result beat per input beat.
// Pipeline: 3 reduction stages, two 4-stage multipliers for radians and square,
// one 5-stage cell per series term, 3 output stages.
// Throughput one beat per cycle; every stage stalls only when full and blocked downstream.
// Reset (rst_n, async, active low) clears all stage valid bits; data registers are not reset.
// Depends on scd_pkg, scd_reduce, scd_mul and scd_cell.
module sine_cosine_degrees_unit #(
    parameter int SERIES_TERMS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] angle_deg
    input  logic        s_tuser,   // [0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [31:0] result
);
    import scd_pkg::*;

    localparam int NT = SERIES_TERMS;

    // reduction to radians
    logic       red_valid, red_ready;
    word_t      red_angle;
    logic       red_cmd;
    logic       rad_valid, rad_ready;
    word_t      x_rad;
    logic [0:0] rad_cmd;
    logic       sq_valid;
    word_t      y_sq;
    logic [64:0] sq_side;

    // cell chain
    logic       c_valid [NT+1];
    logic       c_ready [NT+1];
    word_t      c_prod  [NT+1];
    scd_carry_t c_carry [NT+1];

    // output stages
    logic [2:0]  ov_reg;
    logic [2:0]  old;
    logic [63:0] mag1_reg;
    logic        neg0_reg, neg1_reg;
    logic [64:0] rnd_w;
    logic [38:0] r_w;
    logic [30:0] mag2_next, mag2_reg;
    logic [31:0] res_reg;

    scd_reduce u_reduce (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .angle_deg   ($signed(s_tdata)),
        .command     (s_tuser),
        .out_valid   (red_valid),
        .out_ready   (red_ready),
        .angle_red   (red_angle),
        .command_out (red_cmd)
    );

    // degrees to radians
    scd_mul #(
        .SHIFT  (RAD_SHIFT),
        .SIDE_W (1)
    ) u_rad (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (red_valid),
        .in_ready  (red_ready),
        .a         (red_angle),
        .b         (RAD_PER_DEG),
        .side_in   (red_cmd),
        .out_valid (rad_valid),
        .out_ready (rad_ready),
        .prod      (x_rad),
        .side_out  (rad_cmd)
    );

    // square of the angle
    scd_mul #(
        .SHIFT  (FRAC),
        .SIDE_W (65)
    ) u_sq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rad_valid),
        .in_ready  (rad_ready),
        .a         (x_rad),
        .b         (x_rad),
        .side_in   ({rad_cmd, x_rad}),
        .out_valid (sq_valid),
        .out_ready (c_ready[0]),
        .prod      (y_sq),
        .side_out  (sq_side)
    );

    assign c_valid[0]         = sq_valid;
    assign c_prod[0]          = '0;
    assign c_carry[0].command = sq_side[64];
    assign c_carry[0].x_rad   = word_t'(sq_side[63:0]);
    assign c_carry[0].y_sq    = y_sq;

    // Horner chain, highest term first
    for (genvar i = 0; i < NT; i++)
    begin : g_cell
        scd_cell #(
            .K_IDX (NT - 1 - i),
            .LAST  ((i == NT - 1) ? 1'b1 : 1'b0)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (c_valid[i]),
            .in_ready  (c_ready[i]),
            .prod_in   (c_prod[i]),
            .carry_in  (c_carry[i]),
            .out_valid (c_valid[i+1]),
            .out_ready (c_ready[i+1]),
            .prod_out  (c_prod[i+1]),
            .carry_out (c_carry[i+1])
        );
    end

    // output stall chain
    always_comb
    begin
        old[2] = !ov_reg[2] || m_tready;
        old[1] = !ov_reg[1] || old[2];
        old[0] = !ov_reg[0] || old[1];
    end

    assign c_ready[NT] = old[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= '0;
        end
        else
        begin
            if (old[0])
            begin
                ov_reg[0] <= c_valid[NT];
            end
            if (old[1])
            begin
                ov_reg[1] <= ov_reg[0];
            end
            if (old[2])
            begin
                ov_reg[2] <= ov_reg[1];
            end
        end
    end

    // output stage 0: magnitude of the series value
    always_ff @(posedge clk)
    begin
        if (old[0])
        begin
            mag1_reg <= c_prod[NT][63] ? (64'd0 - 64'(c_prod[NT])) : 64'(c_prod[NT]);
            neg0_reg <= c_prod[NT][63];
        end
    end

    // output stage 1: round to Q2.30 and clamp at one
    always_comb
    begin
        rnd_w = 65'(mag1_reg) + (65'd1 << (OUT_SHIFT - 1));
        r_w   = 39'(rnd_w >> OUT_SHIFT);
        mag2_next = (r_w > 39'(ONE_Q30)) ? ONE_Q30 : r_w[30:0];
    end

    always_ff @(posedge clk)
    begin
        if (old[1])
        begin
            mag2_reg <= mag2_next;
            neg1_reg <= neg0_reg;
        end
    end

    // output stage 2: signed result beat
    always_ff @(posedge clk)
    begin
        if (old[2])
        begin
            res_reg <= neg1_reg ? (32'd0 - 32'(mag2_reg)) : 32'(mag2_reg);
        end
    end

    assign m_tvalid = ov_reg[2];
    assign m_tdata  = res_reg;

`ifndef SYNTHESIS
    // reduced angle in radians stays within [-4, 4)
    a_x_range: assert property (@(posedge clk) disable iff (!rst_n)
        rad_valid |-> (x_rad[63:59] == {5{x_rad[58]}}))
        else $error("radian angle out of range");

    // square of the angle is never negative
    a_y_sign: assert property (@(posedge clk) disable iff (!rst_n)
        sq_valid |-> !y_sq[63])
        else $error("negative square");

    // clamped result stays within plus or minus one
    a_res_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ($signed(m_tdata) <= 32'sd1073741824 &&
                      $signed(m_tdata) >= -32'sd1073741824))
        else $error("result beyond unit range");
`endif

endmodule

/* test/scd_checker.sv */
// result checker for the sine/cosine degrees unit: watches both stream channels,
// predicts each result from the accepted angle beat and compares in order
// depends on scd_pkg for the command codes
module scd_checker #(
    parameter int NUM_TERMS = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] angle_deg
    input  logic        s_tuser,   // [0] command
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,   // [31:0] result
    output int          mismatches,
    output int          outstanding,
    output int          compared
);

    timeunit 1ns;
    timeprecision 1ps;

    import scd_pkg::CMD_SINE;
    import scd_pkg::CMD_COSINE;

    // internal fixed point: 56 fraction bits
    localparam int     FRAC_BITS      = 56;
    localparam int     DEG_SHIFT      = 16 + 60 - FRAC_BITS;
    localparam int     Q30_SHIFT      = FRAC_BITS - 30;
    localparam longint DEG_TO_RAD_Q60 = longint'((64'h3243F6A8885A308D + 64'd90) / 64'd180);
    localparam longint TURN_Q16       = 64'sd360 * 64'sd65536;
    localparam longint HALF_TURN_Q16  = 64'sd180 * 64'sd65536;
    localparam longint UNITY_Q30      = 64'sd1 << 30;
    localparam logic [127:0] MAG_LIMIT = 128'h7FFF_FFFF_FFFF_FFFF;

    // one accepted angle and the result it must produce
    typedef struct {
        logic        cmd;
        logic [31:0] angle;
        logic [31:0] result;
    } trig_answer_t;

    trig_answer_t awaited_answers[$];

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
        compared    = 0;
    end

    // round(a * b / 2^sh) half away from zero, clamped in magnitude to 2^63 - 1
    function automatic longint round_mul(input longint a, input longint b, input int sh);
        logic [63:0]  mag_a;
        logic [63:0]  mag_b;
        logic [127:0] prod;
        logic [127:0] mag;
        logic         neg;
        neg   = (a < 0) != (b < 0);
        mag_a = a[63] ? (64'd0 - a) : a;
        mag_b = b[63] ? (64'd0 - b) : b;
        prod  = {64'd0, mag_a} * {64'd0, mag_b};
        mag   = (prod + (128'd1 << (sh - 1))) >> sh;
        if (mag > MAG_LIMIT)
            mag = MAG_LIMIT;
        return neg ? -longint'(mag[63:0]) : longint'(mag[63:0]);
    endfunction

    // round(2^56 / m!), zero once m! no longer fits 64 bits
    function automatic longint recip_factorial(input int unsigned m);
        logic [63:0] f;
        int unsigned i;
        f = 64'd1;
        if (m > 20)
            return 0;
        for (i = 2; i <= m; i++)
            f = f * i;
        return longint'(((64'd1 << FRAC_BITS) + f / 64'd2) / f);
    endfunction

    // signed taylor coefficient of term k
    function automatic longint series_coeff(input int unsigned k, input logic cmd);
        longint c;
        c = recip_factorial((cmd == CMD_COSINE) ? 2 * k : 2 * k + 1);
        return k[0] ? -c : c;
    endfunction

    // sine or cosine of a Q16.16 degree angle, as Q2.30
    function automatic logic [31:0] trig_of_degrees(input logic cmd,
                                                    input logic signed [31:0] angle);
        longint      turn_frac;
        longint      x_rad;
        longint      y_sq;
        longint      acc;
        longint      total;
        longint      res;
        int unsigned k;
        // exact reduction into [-180, 180], truncating remainder
        turn_frac = longint'(angle) % TURN_Q16;
        if (turn_frac > HALF_TURN_Q16)
            turn_frac -= TURN_Q16;
        if (turn_frac < -HALF_TURN_Q16)
            turn_frac += TURN_Q16;
        x_rad = round_mul(turn_frac, DEG_TO_RAD_Q60, DEG_SHIFT);
        y_sq  = round_mul(x_rad, x_rad, FRAC_BITS);
        // horner evaluation in x squared
        acc = series_coeff(NUM_TERMS - 1, cmd);
        for (k = NUM_TERMS - 1; k > 0; k--)
            acc = series_coeff(k - 1, cmd) + round_mul(y_sq, acc, FRAC_BITS);
        total = (cmd == CMD_COSINE) ? acc : round_mul(x_rad, acc, FRAC_BITS);
        res   = round_mul(total, 1, Q30_SHIFT);
        if (res > UNITY_Q30)
            res = UNITY_Q30;
        if (res < -UNITY_Q30)
            res = -UNITY_Q30;
        return res[31:0];
    endfunction

    // one line per mismatch
    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches = mismatches + 1;
    endtask

    // compare result beats against the oldest prediction, queue new ones
    always @(posedge clk)
    begin
        trig_answer_t got;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (awaited_answers.size() == 0)
                    report_mismatch($sformatf("result beat %h with nothing awaited", m_tdata));
                else
                begin
                    got = awaited_answers.pop_front();
                    compared <= compared + 1;
                    if (m_tdata !== got.result)
                        report_mismatch($sformatf("%s angle %h: result %h, want %h",
                            (got.cmd == CMD_COSINE) ? "cos" : "sin",
                            got.angle, m_tdata, got.result));
                end
            end
            if (s_tvalid && s_tready)
                awaited_answers.push_back('{cmd: s_tuser, angle: s_tdata,
                                            result: trig_of_degrees(s_tuser, s_tdata)});
            outstanding <= awaited_answers.size();
        end
    end

endmodule

/* test/tb_sine_cosine_degrees_unit.sv */
// top of the sine/cosine degrees unit testbench: clock, reset, angle stimulus,
// random backpressure with one long output hold-off, watchdog and verdict
// depends on scd_pkg, sine_cosine_degrees_unit and scd_checker
module tb_sine_cosine_degrees_unit;

    timeunit 1ns;
    timeprecision 1ps;

    import scd_pkg::CMD_SINE;
    import scd_pkg::CMD_COSINE;

    localparam int TERMS        = 10;
    localparam int LATENCY      = 14 + 5 * TERMS;
    localparam int RANDOM_BEATS = 626;
    localparam int HOLD_CYCLES  = 300;
    localparam int QUIET_LIMIT  = 4000;
    localparam int IDLE_PCT     = 27;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = 32'd0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;

    int   mismatches;
    int   outstanding;
    int   compared;
    int   sine_beats = 0;
    int   cosine_beats = 0;
    int   quiet_cycles = 0;
    logic idle_on = 1'b1;
    logic hold_request = 1'b0;

    always #10 clk = ~clk;

    sine_cosine_degrees_unit #(
        .SERIES_TERMS(TERMS)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    scd_checker #(
        .NUM_TERMS(TERMS)
    ) i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .compared    (compared)
    );

    // offer one angle beat, with random idle cycles ahead of it
    task automatic send_angle(input logic cmd, input logic [31:0] angle);
        while (idle_on && $urandom_range(99) < IDLE_PCT)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= angle;
        do
            @(posedge clk);
        while (!s_tready);
        if (cmd == CMD_COSINE)
            cosine_beats++;
        else
            sine_beats++;
    endtask

    task automatic send_both(input logic [31:0] angle);
        send_angle(CMD_SINE, angle);
        send_angle(CMD_COSINE, angle);
    endtask

    // angle stimulus
    initial
    begin
        int          n;
        int          sel;
        int          quadrant;
        int          offset;
        logic        cmd;
        logic [31:0] angle;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // corners: zero, quarter turns, exactly and just past +-180, 32-bit extremes,
        // 30 degrees, wrap of 540 onto 180, smallest step
        send_both(32'h0000_0000);
        send_both(32'h005A_0000);
        send_both(32'hFFA6_0000);
        send_both(32'h00B4_0000);
        send_both(32'hFF4C_0000);
        send_both(32'h00B4_0001);
        send_both(32'hFF4B_FFFF);
        send_both(32'h7FFF_FFFF);
        send_both(32'h8000_0000);
        send_both(32'h001E_0000);
        send_both(32'h021C_0000);
        send_both(32'h0000_0001);

        // random angles: mostly within a little over a turn, some full range,
        // some right around multiples of 90 degrees
        for (n = 0; n < RANDOM_BEATS; n++)
        begin
            idle_on = !(n >= 300 && n < 420);
            if (n == 150)
                hold_request = 1'b1;
            sel = $urandom_range(99);
            cmd = 1'($urandom_range(1));
            if (sel < 55)
                angle = $urandom_range(800 * 65536) - 400 * 65536;
            else if (sel < 80)
                angle = $urandom;
            else
            begin
                quadrant = int'($urandom_range(16)) - 8;
                offset   = int'($urandom_range(8)) - 4;
                angle    = 32'(quadrant * 90 * 65536 + offset);
            end
            send_angle(cmd, angle);
        end
        s_tvalid <= 1'b0;
        @(posedge clk);

        // drain, then a margin for any stray beat
        wait (outstanding == 0);
        repeat (LATENCY + 40) @(posedge clk);

        $display("covered %0d sine and %0d cosine beats, %0d results compared,",
                 sine_beats, cosine_beats, compared);
        $display("with +-180 and 32-bit extreme angles and a %0d-cycle output hold-off",
                 HOLD_CYCLES);
        if (mismatches == 0 && outstanding == 0)
            $display("tb_sine_cosine_degrees_unit OK");
        else
            $display("tb_sine_cosine_degrees_unit NOT OK");
        $finish;
    end

    // result side ready, random stalls plus one long hold-off
    initial
    begin
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            m_tready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // watchdog on cycles with no beat moving on either side
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("tb_sine_cosine_degrees_unit NOT OK");
                $finish;
            end
        end
    end

endmodule

/* sine_cosine_degrees_unit.f */
rtl/core/scd_pkg.sv
rtl/core/scd_mul.sv
rtl/core/scd_reduce.sv
rtl/core/scd_cell.sv
rtl/core/sine_cosine_degrees_unit.sv
test/scd_checker.sv
test/tb_sine_cosine_degrees_unit.sv
